/* hw/rtl/rgb_pixel_format_converter_defines.svh */
// ---------------------------------------------------------------------------
// RGB pixel format converter: assertion macros
// Shared concurrent checks, clocked on the rising edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef RGB_PIXEL_FORMAT_CONVERTER_DEFINES_SVH
`define RGB_PIXEL_FORMAT_CONVERTER_DEFINES_SVH

// Antecedent in this cycle implies consequent in the next one.
`define RPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpf: next-cycle check failed");

// Antecedent implies consequent in the same cycle.
`define RPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpf: same-cycle check failed");

`endif

/* hw/rtl/rpf_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpf_pkg
// Types and constants shared by the pixel format converter modules.
// ---------------------------------------------------------------------------
package rpf_pkg;

  localparam int unsigned PIX_W  = 32;
  localparam int unsigned BPP_W  = 3;
  localparam int unsigned LAY_W  = 10;
  localparam int unsigned IDX_W  = 3;

  // Register indexes
  localparam logic [IDX_W-1:0] CFG_SRC_BPP   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_DST_BPP   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_SRC_RED   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_SRC_GREEN = 3'd3;
  localparam logic [IDX_W-1:0] CFG_SRC_BLUE  = 3'd4;
  localparam logic [IDX_W-1:0] CFG_DST_RED   = 3'd5;
  localparam logic [IDX_W-1:0] CFG_DST_GREEN = 3'd6;
  localparam logic [IDX_W-1:0] CFG_DST_BLUE  = 3'd7;

  // Byte count codes
  localparam logic [BPP_W-1:0] BPP_2 = 3'd2;
  localparam logic [BPP_W-1:0] BPP_3 = 3'd3;
  localparam logic [BPP_W-1:0] BPP_4 = 3'd4;

  typedef struct packed {
    logic [4:0] size;
    logic [4:0] shift;
  } layout_t;

  localparam layout_t LAY_RED_RST   = 10'd272;
  localparam layout_t LAY_GREEN_RST = 10'd264;
  localparam layout_t LAY_BLUE_RST  = 10'd256;

  typedef struct packed {
    logic [BPP_W-1:0] src_bpp;
    logic [BPP_W-1:0] dst_bpp;
    layout_t          src_red;
    layout_t          src_green;
    layout_t          src_blue;
    layout_t          dst_red;
    layout_t          dst_green;
    layout_t          dst_blue;
  } cfg_t;

endpackage

/* hw/rtl/rpf_cfg_regs.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpf_cfg_regs
// Configuration register file: byte counts and channel layouts.
// ---------------------------------------------------------------------------
module rpf_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rpf_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rpf_pkg::LAY_W-1:0]   cfg_data,
  output rpf_pkg::cfg_t               cfg
);
  import rpf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_BPP:   cfg_nxt.src_bpp   = cfg_data[BPP_W-1:0];
        CFG_DST_BPP:   cfg_nxt.dst_bpp   = cfg_data[BPP_W-1:0];
        CFG_SRC_RED:   cfg_nxt.src_red   = cfg_data;
        CFG_SRC_GREEN: cfg_nxt.src_green = cfg_data;
        CFG_SRC_BLUE:  cfg_nxt.src_blue  = cfg_data;
        CFG_DST_RED:   cfg_nxt.dst_red   = cfg_data;
        CFG_DST_GREEN: cfg_nxt.dst_green = cfg_data;
        CFG_DST_BLUE:  cfg_nxt.dst_blue  = cfg_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_bpp   <= BPP_4;
      cfg_r.dst_bpp   <= BPP_4;
      cfg_r.src_red   <= LAY_RED_RST;
      cfg_r.src_green <= LAY_GREEN_RST;
      cfg_r.src_blue  <= LAY_BLUE_RST;
      cfg_r.dst_red   <= LAY_RED_RST;
      cfg_r.dst_green <= LAY_GREEN_RST;
      cfg_r.dst_blue  <= LAY_BLUE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/rpf_channel.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpf_channel
// Extracts one colour channel, rescales it and places it at its target.
// ---------------------------------------------------------------------------
module rpf_channel (
  input  logic [rpf_pkg::PIX_W-1:0] word,
  input  rpf_pkg::layout_t          src_lay,
  input  rpf_pkg::layout_t          dst_lay,
  output logic [rpf_pkg::PIX_W-1:0] moved
);
  import rpf_pkg::*;

  logic [PIX_W-1:0] mask;
  logic [PIX_W-1:0] field;
  logic [PIX_W-1:0] scaled;
  logic [4:0]       up_dist;
  logic [4:0]       down_dist;

  always_comb begin
    mask      = (PIX_W'(1) << src_lay.size) - PIX_W'(1);
    field     = (word >> src_lay.shift) & mask;
    up_dist   = dst_lay.size - src_lay.size;
    down_dist = src_lay.size - dst_lay.size;
    // widen by zero fill on the right, narrow by dropping low bits
    if (dst_lay.size > src_lay.size) begin
      scaled = field << up_dist;
    end else begin
      scaled = field >> down_dist;
    end
    moved = scaled << dst_lay.shift;
  end

endmodule

/* hw/rtl/rgb_pixel_format_converter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_pixel_format_converter
// Repacks one RGB pixel per clock from a source to a destination layout.
// ---------------------------------------------------------------------------
//  channel   handshake          data
//  input     start / busy       in_src_pixel
//  result    out_valid strobe   out_dest_pixel, out_bad_format
//  config    cfg_we             cfg_index, cfg_data
//
//  A taken beat reaches its result strobe through the pipe:
//  an input register, then the channel shifters, then the result register.
//  busy stays low; one beat is taken every clock and the receiver cannot stall.
//  Reset (synchronous, rst_n low) clears the pipe valids and loads the
//  register defaults: 4 bytes in and out, 8:8:8 layout.
module rgb_pixel_format_converter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [rpf_pkg::PIX_W-1:0]   in_src_pixel,
  output logic                        out_valid,
  output logic [rpf_pkg::PIX_W-1:0]   out_dest_pixel,
  output logic                        out_bad_format,
  input  logic                        cfg_we,
  input  logic [rpf_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rpf_pkg::LAY_W-1:0]   cfg_data
);
  import rpf_pkg::*;
  `include "rgb_pixel_format_converter_defines.svh"

  cfg_t             cfg;
  logic             in_vld_r;
  logic [PIX_W-1:0] pix_r;
  logic [PIX_W-1:0] word;
  logic [PIX_W-1:0] keep;
  logic             src_ok;
  logic             dst_ok;
  logic [PIX_W-1:0] red_mv;
  logic [PIX_W-1:0] green_mv;
  logic [PIX_W-1:0] blue_mv;
  logic [PIX_W-1:0] dest_nxt;
  logic             bad_nxt;
  logic             out_vld_r;
  logic [PIX_W-1:0] dest_r;
  logic             bad_r;

  rpf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= in_src_pixel;
  end

  always_comb begin
    src_ok = 1'b1;
    word   = pix_r;
    case (cfg.src_bpp)
      BPP_2:   word = {16'h0000, pix_r[15:0]};
      BPP_4:   word = pix_r;
      default: src_ok = 1'b0;
    endcase
    dst_ok = 1'b1;
    keep   = '1;
    case (cfg.dst_bpp)
      BPP_2:   keep = 32'h0000_FFFF;
      BPP_3:   keep = 32'h00FF_FFFF;
      BPP_4:   keep = 32'hFFFF_FFFF;
      default: dst_ok = 1'b0;
    endcase
  end

  rpf_channel u_red (
    .word    (word),
    .src_lay (cfg.src_red),
    .dst_lay (cfg.dst_red),
    .moved   (red_mv)
  );

  rpf_channel u_green (
    .word    (word),
    .src_lay (cfg.src_green),
    .dst_lay (cfg.dst_green),
    .moved   (green_mv)
  );

  rpf_channel u_blue (
    .word    (word),
    .src_lay (cfg.src_blue),
    .dst_lay (cfg.dst_blue),
    .moved   (blue_mv)
  );

  always_comb begin
    bad_nxt = !(src_ok && dst_ok);
    // drop the pixel on a bad byte count
    dest_nxt = bad_nxt ? '0 : ((red_mv | green_mv | blue_mv) & keep);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dest_r <= dest_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_dest_pixel = dest_r;
  assign out_bad_format = bad_r;

  `RPF_ASSERT_NEXT(a_take_beat, clk, rst_n, start && !busy, in_vld_r)
  `RPF_ASSERT_NEXT(a_beat_to_result, clk, rst_n, in_vld_r, out_valid)
  `RPF_ASSERT_NEXT(a_no_stray_result, clk, rst_n, !in_vld_r, !out_valid)
  `RPF_ASSERT_SAME(a_bad_is_zero, clk, rst_n, out_valid && out_bad_format, dest_r == '0)

endmodule
